// ----- design/cpr_pkg.sv -----
// ============================================================================
// cpr_pkg - shared types and constants for the clock page replacement block
// Payload structs for both channels, sequencer states and default sizes.
// ============================================================================
package cpr_pkg;

    // Default sizes handed to the top-level parameters
    localparam int NUM_PAGES_DEF  = 32;
    localparam int NUM_FRAMES_DEF = 4;

    // Fixed field widths
    localparam int ADDR_W      = 32;
    localparam int SPAN_W      = 21;
    localparam int FRAME_IDX_W = 2;

    localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(1024);

    // Input item: one address
    typedef struct packed {
        logic [ADDR_W-1:0] address;
    } addr_item_t;

    // Result item: one occupied frame, or a no-match flag
    typedef struct packed {
        logic [ADDR_W-1:0]      page_base;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   was_hit;
        logic                   no_match;
        logic                   last;
    } result_item_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_SWEEP,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_NOMATCH
    } cpr_state_t;

endpackage

// ----- design/cpr_stream_if.sv -----
// ============================================================================
// cpr_stream_if - valid/ready stream channel
// Carries one payload item per transfer; a transfer happens at a rising edge
// with valid and ready both high.
// ============================================================================
interface cpr_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/cpr_ram.sv -----
// ============================================================================
// cpr_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
module cpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/cpr_range_cmp.sv -----
// ============================================================================
// cpr_range_cmp - page range compare unit
// Checks base <= address < base + span, with the end computed without wrap.
// ============================================================================
module cpr_range_cmp (
    input  logic [cpr_pkg::ADDR_W-1:0] base,
    input  logic [cpr_pkg::ADDR_W-1:0] address,
    input  logic [cpr_pkg::SPAN_W-1:0] span,
    output logic                       match
);

    logic [cpr_pkg::ADDR_W:0] range_end;

    // 33-bit end so a page near the top of the space ends at the top
    assign range_end = {1'b0, base} + {{(cpr_pkg::ADDR_W + 1 - cpr_pkg::SPAN_W){1'b0}}, span};
    assign match     = (base <= address) && (range_end > {1'b0, address});

endmodule

// ----- design/clock_page_replacement.sv -----
// ============================================================================
// clock_page_replacement - second-chance page replacement over a page table
// Range scan over loaded page bases, clock-hand frame allocation and a
// per-access report of every occupied frame.
// ============================================================================
// Usage:
//   addr_ch (sink) takes one address per transfer. The first NUM_PAGES
//   transfers load page base addresses into the page table and produce no
//   result. Every later transfer is an access.
//   result_ch (source) returns, per access, one item for each occupied frame
//   in frame order with last set on the final one, or a single item with
//   no_match and last set when no page range holds the address.
//   cfg_we/cfg_wdata write page_span (reset 1024); write only while idle.
//   Access sequence: the accept, a page table scan of one entry per cycle
//   through the shared compare unit, stopping at the first match, a resolve
//   step, on a miss one clock-hand step per cycle, then the report: empty
//   frames are skipped and each occupied frame is read and then emitted,
//   up to the last occupied frame. addr_ch is not ready meanwhile.
//   Results pass through an output register; when result_ch stalls the
//   sequencer holds until the register frees. The last result may wait
//   there while the next item is taken.
//   Reset clears the load count, residency, frame flags and clock hand;
//   page table contents need no clearing pass.
// ============================================================================
module clock_page_replacement #(
    parameter int NUM_PAGES  = cpr_pkg::NUM_PAGES_DEF,
    parameter int NUM_FRAMES = cpr_pkg::NUM_FRAMES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cpr_pkg::SPAN_W-1:0] cfg_wdata,
    cpr_stream_if.sink                 addr_ch,
    cpr_stream_if.source               result_ch
);

    localparam int PAGE_W  = $clog2(NUM_PAGES);
    localparam int LOAD_W  = $clog2(NUM_PAGES + 1);
    localparam int FRAME_W = $clog2(NUM_FRAMES);

    // Control state
    cpr_pkg::cpr_state_t         state_reg, state_next;
    logic [cpr_pkg::SPAN_W-1:0]  span_reg, span_next;
    logic [LOAD_W-1:0]           loaded_count_reg, loaded_count_next;
    logic [NUM_PAGES-1:0]        resident_reg, resident_next;
    logic [NUM_FRAMES-1:0]       occ_reg, occ_next;
    logic [NUM_FRAMES-1:0]       ref_reg, ref_next;
    logic [FRAME_W-1:0]          hand_reg, hand_next;
    logic                        out_valid_reg, out_valid_next;

    // Payload and working registers
    logic [cpr_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic [PAGE_W-1:0]           scan_idx_reg, scan_idx_next;
    logic [PAGE_W-1:0]           pg_reg, pg_next;
    logic                        hit_reg, hit_next;
    logic [FRAME_W-1:0]          frame_idx_reg, frame_idx_next;
    logic [FRAME_W-1:0]          page_frame_reg [NUM_PAGES];
    logic [FRAME_W-1:0]          page_frame_next [NUM_PAGES];
    logic [PAGE_W-1:0]           frame_page_reg [NUM_FRAMES];
    logic [PAGE_W-1:0]           frame_page_next [NUM_FRAMES];
    cpr_pkg::result_item_t       out_data_reg, out_data_next;

    // Page table memory and compare unit
    logic                        ram_we;
    logic [PAGE_W-1:0]           ram_waddr;
    logic [PAGE_W-1:0]           ram_raddr;
    logic [cpr_pkg::ADDR_W-1:0]  ram_rdata;
    logic                        range_match;
    logic                        in_fire;
    logic                        out_free;
    logic                        is_last;

    cpr_ram #(
        .WIDTH (cpr_pkg::ADDR_W),
        .DEPTH (NUM_PAGES)
    ) u_page_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (addr_ch.data.address),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cpr_range_cmp u_range_cmp (
        .base    (ram_rdata),
        .address (addr_reg),
        .span    (span_reg),
        .match   (range_match)
    );

    assign addr_ch.ready   = (state_reg == cpr_pkg::ST_IDLE);
    assign in_fire         = addr_ch.valid && addr_ch.ready;
    assign out_free        = !out_valid_reg || result_ch.ready;
    assign result_ch.valid = out_valid_reg;
    assign result_ch.data  = out_data_reg;
    assign ram_waddr       = loaded_count_reg[PAGE_W-1:0];

    // Last occupied frame: nothing occupied above the current frame
    always_comb
    begin
        is_last = 1'b1;
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            if ((FRAME_W'(i) > frame_idx_reg) && occ_reg[i])
            begin
                is_last = 1'b0;
            end
        end
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next        = state_reg;
        span_next         = cfg_we ? cfg_wdata : span_reg;
        loaded_count_next = loaded_count_reg;
        resident_next     = resident_reg;
        occ_next          = occ_reg;
        ref_next          = ref_reg;
        hand_next         = hand_reg;
        addr_next         = addr_reg;
        scan_idx_next     = scan_idx_reg;
        pg_next           = pg_reg;
        hit_next          = hit_reg;
        frame_idx_next    = frame_idx_reg;
        page_frame_next   = page_frame_reg;
        frame_page_next   = frame_page_reg;
        out_data_next     = out_data_reg;
        out_valid_next    = out_valid_reg && !result_ch.ready;
        ram_we            = 1'b0;
        ram_raddr         = '0;

        unique case (state_reg)
            cpr_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (loaded_count_reg < LOAD_W'(NUM_PAGES))
                    begin
                        ram_we            = 1'b1;
                        loaded_count_next = loaded_count_reg + 1'b1;
                    end
                    else
                    begin
                        addr_next     = addr_ch.data.address;
                        scan_idx_next = '0;
                        ram_raddr     = '0;
                        state_next    = cpr_pkg::ST_SCAN;
                    end
                end
            end

            // One table entry per cycle through the compare unit
            cpr_pkg::ST_SCAN:
            begin
                ram_raddr = scan_idx_reg + 1'b1;
                if (range_match)
                begin
                    pg_next    = scan_idx_reg;
                    state_next = cpr_pkg::ST_RESOLVE;
                end
                else if (scan_idx_reg == PAGE_W'(NUM_PAGES - 1))
                begin
                    state_next = cpr_pkg::ST_NOMATCH;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            cpr_pkg::ST_RESOLVE:
            begin
                hit_next       = resident_reg[pg_reg];
                frame_idx_next = '0;
                if (resident_reg[pg_reg])
                begin
                    ref_next[page_frame_reg[pg_reg]] = 1'b1;
                    state_next = cpr_pkg::ST_EMIT_RD;
                end
                else
                begin
                    state_next = cpr_pkg::ST_SWEEP;
                end
            end

            // Clock hand: clear referenced frames until a clear one, then install
            cpr_pkg::ST_SWEEP:
            begin
                hand_next = (hand_reg == FRAME_W'(NUM_FRAMES - 1)) ? '0 : hand_reg + 1'b1;
                if (ref_reg[hand_reg])
                begin
                    ref_next[hand_reg] = 1'b0;
                end
                else
                begin
                    if (occ_reg[hand_reg])
                    begin
                        resident_next[frame_page_reg[hand_reg]] = 1'b0;
                    end
                    ref_next[hand_reg]        = 1'b1;
                    occ_next[hand_reg]        = 1'b1;
                    frame_page_next[hand_reg] = pg_reg;
                    resident_next[pg_reg]     = 1'b1;
                    page_frame_next[pg_reg]   = hand_reg;
                    state_next                = cpr_pkg::ST_EMIT_RD;
                end
            end

            // Skip empty frames, read the base of an occupied one
            cpr_pkg::ST_EMIT_RD:
            begin
                ram_raddr = frame_page_reg[frame_idx_reg];
                if (occ_reg[frame_idx_reg])
                begin
                    state_next = cpr_pkg::ST_EMIT_WAIT;
                end
                else
                begin
                    frame_idx_next = frame_idx_reg + 1'b1;
                end
            end

            // Base is ready; load the output register when it frees
            cpr_pkg::ST_EMIT_WAIT:
            begin
                ram_raddr = frame_page_reg[frame_idx_reg];
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.page_base   = ram_rdata;
                    out_data_next.frame_index = cpr_pkg::FRAME_IDX_W'(frame_idx_reg);
                    out_data_next.was_hit     = hit_reg;
                    out_data_next.no_match    = 1'b0;
                    out_data_next.last        = is_last;
                    if (is_last)
                    begin
                        state_next = cpr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        frame_idx_next = frame_idx_reg + 1'b1;
                        state_next     = cpr_pkg::ST_EMIT_RD;
                    end
                end
            end

            cpr_pkg::ST_NOMATCH:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.page_base   = '0;
                    out_data_next.frame_index = '0;
                    out_data_next.was_hit     = 1'b0;
                    out_data_next.no_match    = 1'b1;
                    out_data_next.last        = 1'b1;
                    state_next                = cpr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cpr_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cpr_pkg::ST_IDLE;
            span_reg         <= cpr_pkg::SPAN_RESET;
            loaded_count_reg <= '0;
            resident_reg     <= '0;
            occ_reg          <= '0;
            ref_reg          <= '0;
            hand_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            span_reg         <= span_next;
            loaded_count_reg <= loaded_count_next;
            resident_reg     <= resident_next;
            occ_reg          <= occ_next;
            ref_reg          <= ref_next;
            hand_reg         <= hand_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg        <= addr_next;
        scan_idx_reg    <= scan_idx_next;
        pg_reg          <= pg_next;
        hit_reg         <= hit_next;
        frame_idx_reg   <= frame_idx_next;
        page_frame_reg  <= page_frame_next;
        frame_page_reg  <= frame_page_next;
        out_data_reg    <= out_data_next;
    end

endmodule

// ----- dv/clock_page_replacement_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// clock_page_replacement_tb - self-checking bench for the page replacement block
// Loads a partly random page table, walks a directed table of accesses and span
// settings, then runs random accesses over a few hot pages per phase. Every
// result transfer is compared field by field against a typed directed result
// or a behavioral copy of the clock hand, frame flags and residency.
// ============================================================================
module clock_page_replacement_tb;

    localparam int NUM_PAGES     = cpr_pkg::NUM_PAGES_DEF;
    localparam int NUM_FRAMES    = cpr_pkg::NUM_FRAMES_DEF;
    localparam int ADDR_W        = cpr_pkg::ADDR_W;
    localparam int SPAN_W        = cpr_pkg::SPAN_W;
    localparam int FRAME_IDX_W   = cpr_pkg::FRAME_IDX_W;
    localparam int SETTLE_CYCLES = 128;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 17;
    localparam int HOT_PAGES     = 6;
    localparam logic [SPAN_W-1:0] SPAN_MAX = SPAN_W'(1048576);

    // Directed table: either a span write or one access
    typedef enum logic {
        ROW_CONFIG,
        ROW_ACCESS
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [31:0]           value;
        logic                  typed;
        cpr_pkg::result_item_t typed_result;
    } dir_row_t;

    // Results that can be read straight off the behavior
    localparam cpr_pkg::result_item_t FIRST_FILL_RESULT = '{
        page_base: 32'h0, frame_index: 2'd0, was_hit: 1'b0, no_match: 1'b0, last: 1'b1};
    localparam cpr_pkg::result_item_t NOMATCH_RESULT = '{
        page_base: 32'h0, frame_index: 2'd0, was_hit: 1'b0, no_match: 1'b1, last: 1'b1};

    localparam int NUM_DIRECTED = 24;
    localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // span 1024 from reset
        '{ROW_ACCESS, 32'h0000_0000, 1'b1, FIRST_FILL_RESULT},  // page 0 into empty frame 0
        '{ROW_ACCESS, 32'h0000_03FF, 1'b0, '0},                 // top of page 0, hit
        '{ROW_ACCESS, 32'h0000_0400, 1'b0, '0},                 // past page 0, inside page 1
        '{ROW_ACCESS, 32'hFFFF_FFFF, 1'b0, '0},                 // range clipped at the top
        '{ROW_ACCESS, 32'h0000_0800, 1'b1, NOMATCH_RESULT},     // gap between pages
        '{ROW_ACCESS, 32'h0200_0000, 1'b0, '0},                 // fills last frame
        '{ROW_ACCESS, 32'h0300_03FF, 1'b0, '0},                 // full sweep, evict frame 0
        '{ROW_ACCESS, 32'h0000_0000, 1'b0, '0},
        '{ROW_ACCESS, 32'h0000_0500, 1'b1, NOMATCH_RESULT},     // one past page 1
        '{ROW_ACCESS, 32'h0400_0200, 1'b0, '0},
        '{ROW_ACCESS, 32'h0000_01FF, 1'b0, '0},                 // overlap, lowest page wins
        // smallest span
        '{ROW_CONFIG, 32'd1,         1'b0, '0},
        '{ROW_ACCESS, 32'h0000_0001, 1'b1, NOMATCH_RESULT},
        '{ROW_ACCESS, 32'hFFFF_FFFF, 1'b0, '0},                 // only the topmost page
        '{ROW_ACCESS, 32'h0500_0000, 1'b0, '0},
        // largest span
        '{ROW_CONFIG, 32'd1048576,   1'b0, '0},
        '{ROW_ACCESS, 32'h000F_FFFF, 1'b0, '0},
        '{ROW_ACCESS, 32'h0010_0000, 1'b0, '0},
        '{ROW_ACCESS, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_ACCESS, 32'h0010_00FF, 1'b0, '0},
        // zero span: nothing matches
        '{ROW_CONFIG, 32'd0,         1'b0, '0},
        '{ROW_ACCESS, 32'h0000_0000, 1'b1, NOMATCH_RESULT},
        '{ROW_ACCESS, 32'hFFFF_FFFF, 1'b1, NOMATCH_RESULT},
        '{ROW_CONFIG, 32'd1024,      1'b0, '0}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [SPAN_W-1:0] cfg_wdata;

    cpr_stream_if #(.item_t(cpr_pkg::addr_item_t))   addr_if ();
    cpr_stream_if #(.item_t(cpr_pkg::result_item_t)) result_if ();

    clock_page_replacement DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .addr_ch   (addr_if),
        .result_ch (result_if)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Bench copy of the replacement state
    logic [ADDR_W-1:0] table_base [NUM_PAGES];
    logic              page_resident [NUM_PAGES];
    int                page_frame [NUM_PAGES];
    int                frame_page [NUM_FRAMES];
    logic              frame_used [NUM_FRAMES];
    logic              frame_referenced [NUM_FRAMES];
    int                clock_hand;
    int                pages_loaded;
    logic [SPAN_W-1:0] span_q;

    cpr_pkg::result_item_t frame_report [$];
    cpr_pkg::result_item_t pending_reports [$];
    cpr_pkg::result_item_t oldest_report;
    logic [ADDR_W-1:0]     page_bases [NUM_PAGES];
    int                    hot_page [HOT_PAGES];
    int unsigned           mismatch_count = 0;
    int unsigned           cycle_count = 0;
    bit                    idle_on = 1'b1;

    // Work out the frame report one address causes, updating the state copy
    function automatic void predict_frame_report(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W:0]       range_end;
        int                    match_page;
        logic                  hit;
        cpr_pkg::result_item_t item;
        frame_report.delete();
        if (pages_loaded < NUM_PAGES)
        begin
            table_base[pages_loaded] = addr;
            pages_loaded++;
            return;
        end
        // Lowest page whose range holds the address; end does not wrap
        match_page = -1;
        for (int k = 0; k < NUM_PAGES; k++)
        begin
            range_end = {1'b0, table_base[k]} + (ADDR_W + 1)'(span_q);
            if (match_page < 0 && table_base[k] <= addr && range_end > {1'b0, addr})
                match_page = k;
        end
        if (match_page < 0)
        begin
            frame_report.push_back(NOMATCH_RESULT);
            return;
        end
        hit = page_resident[match_page];
        if (hit)
            frame_referenced[page_frame[match_page]] = 1'b1;
        else
        begin
            // Second chance: clear referenced bits until a clear one
            while (frame_referenced[clock_hand])
            begin
                frame_referenced[clock_hand] = 1'b0;
                clock_hand = (clock_hand == NUM_FRAMES - 1) ? 0 : clock_hand + 1;
            end
            if (frame_used[clock_hand])
                page_resident[frame_page[clock_hand]] = 1'b0;
            frame_referenced[clock_hand] = 1'b1;
            frame_used[clock_hand]       = 1'b1;
            frame_page[clock_hand]       = match_page;
            page_resident[match_page]    = 1'b1;
            page_frame[match_page]       = clock_hand;
            clock_hand = (clock_hand == NUM_FRAMES - 1) ? 0 : clock_hand + 1;
        end
        // One item per occupied frame, in frame order
        for (int f = 0; f < NUM_FRAMES; f++)
        begin
            if (frame_used[f])
            begin
                item.page_base   = table_base[frame_page[f]];
                item.frame_index = FRAME_IDX_W'(f);
                item.was_hit     = hit;
                item.no_match    = 1'b0;
                item.last        = 1'b0;
                frame_report.push_back(item);
            end
        end
        frame_report[frame_report.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Drive one address, wait for its transfer, queue what it should produce
    task automatic send_address(input logic [ADDR_W-1:0] addr, input logic typed,
                                input cpr_pkg::result_item_t typed_result);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            addr_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        addr_if.valid        <= 1'b1;
        addr_if.data.address <= addr;
        @(posedge clk);
        while (!addr_if.ready)
            @(posedge clk);
        predict_frame_report(addr);
        if (typed)
            pending_reports.push_back(typed_result);
        else
            foreach (frame_report[i])
                pending_reports.push_back(frame_report[i]);
    endtask

    // Span write once every result is out and the block has settled
    task automatic write_page_span(input logic [SPAN_W-1:0] span);
        @(negedge clk);
        addr_if.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= span;
        @(negedge clk);
        cfg_we <= 1'b0;
        span_q = span;
    endtask

    // Result side: random stall bursts while idling is on
    initial
    begin
        int stall;
        result_if.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                result_if.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(0, 15);
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result with none expected: page_base %h frame_index %0d",
                       result_if.data.page_base, result_if.data.frame_index);
                mismatch_count++;
            end
            else
            begin
                oldest_report = pending_reports.pop_front();
                check_field("page_base", oldest_report.page_base, result_if.data.page_base);
                check_field("frame_index", 32'(oldest_report.frame_index),
                            32'(result_if.data.frame_index));
                check_field("was_hit", 32'(oldest_report.was_hit), 32'(result_if.data.was_hit));
                check_field("no_match", 32'(oldest_report.no_match),
                            32'(result_if.data.no_match));
                check_field("last", 32'(oldest_report.last), 32'(result_if.data.last));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence
    initial
    begin
        logic [SPAN_W-1:0] phase_span;
        logic [ADDR_W:0]   sum;
        logic [ADDR_W-1:0] addr;
        int                pick;
        int                page;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = cpr_pkg::SPAN_RESET;
        addr_if.valid        = 1'b0;
        addr_if.data.address = '0;

        span_q       = cpr_pkg::SPAN_RESET;
        clock_hand   = 0;
        pages_loaded = 0;
        for (int k = 0; k < NUM_PAGES; k++)
        begin
            page_resident[k] = 1'b0;
            page_frame[k]    = 0;
        end
        for (int f = 0; f < NUM_FRAMES; f++)
        begin
            frame_used[f]       = 1'b0;
            frame_referenced[f] = 1'b0;
            frame_page[f]       = 0;
        end

        // Page table: overlapping pair at zero, fixed low pages, random upper
        // pages, one near-overlapping pair, two pages at the very top
        for (int k = 0; k < NUM_PAGES; k++)
        begin
            if (k == 0)
                page_bases[k] = 32'h0000_0000;
            else if (k == 1)
                page_bases[k] = 32'h0000_0100;
            else if (k < 10)
                page_bases[k] = 32'(k) << 24;
            else if (k == 21)
                page_bases[k] = page_bases[20] + 32'($urandom_range(0, 32'hFFFF));
            else if (k == 30)
                page_bases[k] = 32'hFFFF_F000;
            else if (k == 31)
                page_bases[k] = 32'hFFFF_FFFF;
            else
                page_bases[k] = {5'(k), 27'($urandom())};
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Load phase
        for (int k = 0; k < NUM_PAGES; k++)
            send_address(page_bases[k], 1'b0, '0);

        // Directed rows
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (DIRECTED_ROWS[i].kind == ROW_CONFIG)
                write_page_span(SPAN_W'(DIRECTED_ROWS[i].value));
            else
                send_address(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed,
                             DIRECTED_ROWS[i].typed_result);
        end

        // Random phases, each with its own span and hot page set
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: phase_span = SPAN_W'($urandom_range(1, 1048576));
                1: phase_span = SPAN_W'(16);
                2: phase_span = SPAN_MAX;
                default: phase_span = cpr_pkg::SPAN_RESET;
            endcase
            if (p == RANDOM_PHASES - 1)
                idle_on = 1'b0;
            write_page_span(phase_span);
            for (int h = 0; h < HOT_PAGES; h++)
                hot_page[h] = $urandom_range(0, NUM_PAGES - 1);
            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    addr = $urandom();
                else
                begin
                    if (pick < 70)
                        page = hot_page[$urandom_range(0, HOT_PAGES - 1)];
                    else
                        page = $urandom_range(0, NUM_PAGES - 1);
                    sum  = {1'b0, page_bases[page]}
                         + (ADDR_W + 1)'($urandom_range(32'(span_q) - 1, 0));
                    addr = sum[ADDR_W] ? 32'hFFFF_FFFF : sum[ADDR_W-1:0];
                end
                send_address(addr, 1'b0, '0);
            end
        end

        // Drain and settle
        @(negedge clk);
        addr_if.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
design/cpr_pkg.sv
design/cpr_stream_if.sv
design/cpr_ram.sv
design/cpr_range_cmp.sv
design/clock_page_replacement.sv
dv/clock_page_replacement_tb.sv
